// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; take in by include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define RPL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rpl assertion failed");

// condition that must never hold outside reset
`define RPL_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rpl forbidden condition seen");

`endif

// ===== hdl/rpl_pkg.sv =====
// shared types, codes and sizes of the replay protection list
// no dependencies
`default_nettype none

package rpl_pkg;

  localparam int ENTRIES = 32;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int SRC_W = 16;
  localparam int SEQ_W = 24;
  localparam int IV_W = 32;
  localparam int KIND_W = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 6;
  localparam int ACT_W = 6;

  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REPLAY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // word address of the active_entries register
  localparam logic REG_ACTIVE = 1'b0;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [SEQ_W-1:0] seq;
    logic [IV_W-1:0]  iv;
  } req_t;

  typedef struct packed {
    logic             cmp_en;
    logic             wr_upd;
    logic             wr_app;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  typedef struct packed {
    logic hit;
    logic replay;
  } chain_t;

endpackage

`default_nettype wire

// ===== hdl/rpl_cell.sv =====
// one table entry with its own source compare and replay test
// depends on rpl_pkg
`default_nettype none

module rpl_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  wire [rpl_pkg::CNT_W-1:0] idx,
  input  wire rpl_pkg::req_t      req,
  input  wire rpl_pkg::cell_ctl_t ctl,
  input  wire rpl_pkg::chain_t    chain_in,
  output rpl_pkg::chain_t         chain_out
);

  logic [rpl_pkg::SRC_W-1:0] src;
  logic [rpl_pkg::SEQ_W-1:0] seq;
  logic [rpl_pkg::IV_W-1:0]  iv;
  logic                      match;
  logic                      replay;

  always_ff @(posedge clk) begin
    if (rst) begin
      match  <= 1'b0;
      replay <= 1'b0;
    end else if (ctl.cmp_en) begin
      // only entries below the fill count take part
      match  <= (idx < ctl.count) && (src == req.src);
      replay <= (req.seq <= seq) || (req.iv < iv);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_app && (idx == ctl.count)) begin
      src <= req.src;
      seq <= req.seq;
      iv  <= req.iv;
    end else if (ctl.wr_upd && match) begin
      seq <= req.seq;
      iv  <= req.iv;
    end
  end

  assign chain_out.hit    = chain_in.hit | match;
  assign chain_out.replay = chain_in.replay | (match & replay);

endmodule

`default_nettype wire

// ===== hdl/replay_protection_list_top.sv =====
// top level: stream ports, register port, request control and the row of entry cells
// depends on rpl_pkg and rpl_cell
`default_nettype none

// Replay protection list. Each request goes through these steps from acceptance to
// result: it is latched, every cell compares its entry with the source, and then the
// hit and replay flags are collected along the row of cells, an update writes the table and
// the result is loaded into the output register once that register is free. The next
// request is accepted in the cycle after the result is loaded, even while that
// result still waits on m_tready; a new request is never taken before the last
// result is loaded. The table holds up to 32 entries; active_entries limits appending. There
// is no clearing pass: a clear request empties the table at once.

module replay_protection_list_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [71:0] s_tdata,   // src[15:0], seq[39:16], iv[71:40]
  input  wire [1:0]  s_tuser,   // kind[1:0]
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [15:0] m_tdata,  // status[1:0], full_res[2], occupancy[8:3], zero[15:9]
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [rpl_pkg::ACT_W-1:0]    active_entries;
  logic [rpl_pkg::CNT_W-1:0]    count;
  logic [rpl_pkg::CNT_W-1:0]    count_next;
  logic [rpl_pkg::CNT_W-1:0]    cap;
  logic [rpl_pkg::KIND_W-1:0]   kind;
  rpl_pkg::req_t                req;
  rpl_pkg::cell_ctl_t           ctl;
  rpl_pkg::chain_t              chain [rpl_pkg::ENTRIES+1];
  logic [rpl_pkg::STATUS_W-1:0] status;
  logic                         room;
  logic                         go;

  // register port
  assign pready = 1'b1;
  assign prdata = {{(32 - rpl_pkg::ACT_W){1'b0}}, active_entries};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= rpl_pkg::ACT_W'(32);
    end else if (psel && penable && pwrite && (paddr[2] == rpl_pkg::REG_ACTIVE)) begin
      active_entries <= pwdata[rpl_pkg::ACT_W-1:0];
    end
  end

  // capacity saturates at the table size
  always_comb begin
    if (32'(active_entries) > 32'(rpl_pkg::ENTRIES)) begin
      cap = rpl_pkg::CNT_W'(rpl_pkg::ENTRIES);
    end else begin
      cap = rpl_pkg::CNT_W'(active_entries);
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign go       = (state == ST_RES) && (!m_tvalid || m_tready);
  assign room     = count < cap;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind    <= s_tuser;
      req.src <= s_tdata[15:0];
      req.seq <= s_tdata[39:16];
      req.iv  <= s_tdata[71:40];
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = (s_tvalid) ? ST_CMP : ST_IDLE;
      ST_CMP:  state_next = ST_RES;
      ST_RES:  state_next = (go) ? ST_IDLE : ST_RES;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row of entry cells; hit and replay ripple from cell to cell
  assign ctl.cmp_en = (state == ST_CMP);
  assign ctl.wr_upd = go && (kind == rpl_pkg::KIND_UPDATE) && chain[rpl_pkg::ENTRIES].hit;
  assign ctl.wr_app = go && (kind == rpl_pkg::KIND_UPDATE) && !chain[rpl_pkg::ENTRIES].hit
                      && room;
  assign ctl.count  = count;

  assign chain[0] = '0;

  for (genvar g = 0; g < rpl_pkg::ENTRIES; g++) begin : g_cell
    rpl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (rpl_pkg::CNT_W'(g)),
      .req       (req),
      .ctl       (ctl),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  always_comb begin
    status     = rpl_pkg::STATUS_OK;
    count_next = count;
    unique case (kind)
      rpl_pkg::KIND_CHECK: begin
        if (chain[rpl_pkg::ENTRIES].replay) begin
          status = rpl_pkg::STATUS_REPLAY;
        end
      end
      rpl_pkg::KIND_UPDATE: begin
        if (!chain[rpl_pkg::ENTRIES].hit) begin
          if (room) begin
            count_next = count + 1'b1;
          end else begin
            status = rpl_pkg::STATUS_FULL;
          end
        end
      end
      rpl_pkg::KIND_CLEAR: count_next = '0;
      default: status = rpl_pkg::STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {7'b0, rpl_pkg::OCC_W'(count_next), (count_next >= cap), status};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpl_checker.sv =====
// port-level checks on the replay protection list, bound to the top level
// depends on rpl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rpl_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata
);

  // a waiting result holds
  `RPL_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // occupancy never goes past the table size
  `RPL_NEVER(a_occ_range, clk, rst, m_tvalid && (32'(m_tdata[8:3]) > 32'(rpl_pkg::ENTRIES)))
  // a full report always comes with the full flag set
  `RPL_ASSERT(a_full_flag, clk, rst, m_tvalid && (m_tdata[1:0] == rpl_pkg::STATUS_FULL) |-> m_tdata[2])
  // status code three is never produced
  `RPL_NEVER(a_status_code, clk, rst, m_tvalid && (m_tdata[1:0] == 2'd3))
  // one request at a time: no acceptance in the cycle after one
  `RPL_ASSERT(a_one_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready)

endmodule

bind replay_protection_list_top rpl_checker u_rpl_checker (.*);

`default_nettype wire
